// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/ffe_pkg.sv =====
`timescale 1ns / 1ps

package ffe_pkg;

   localparam int ROW_BITS      = 6;
   localparam int COL_BITS      = 6;
   localparam int VALUE_BITS    = 16;
   localparam int SIZE_BITS     = 7;
   localparam int EXT_BITS      = 11;  // holds any size up to 1024 and any register value
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 16;
   localparam int TUSER_KIND    = 0;
   localparam int TUSER_OOR     = 1;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = 7'd64;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_FILL = 2'd1,
      CMD_READ = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic {
      KIND_READ = 1'b0,
      KIND_FILL = 1'b1
   } kind_type;

   typedef enum logic {
      CSR_ROWS = 1'b0,
      CSR_COLS = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_RIGHT = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [ROW_BITS-1:0]    row;
      logic [COL_BITS-1:0]    col;
      logic [VALUE_BITS-1:0]  value;
      logic                   bad;
   } cmd_in_type;

   typedef struct packed {
      kind_type               kind;
      logic [VALUE_BITS-1:0]  color;
      logic                   oor;
   } rsp_type;

endpackage

// ===== hdl/flood_fill_4way_engine_top.sv =====
`timescale 1ns / 1ps

// 4-connected flood fill over an on-chip pixel memory. Send load transactions
// (cmd 0) to write pixels, read transactions (cmd 2) to get one pixel back,
// and a fill transaction (cmd 1) to recolor every pixel 4-connected to the
// seed that has the seed's color. Pixels live at row * MAX_COLS + col in a
// one-port-read, one-port-write synchronous RAM; a second RAM of the same
// depth holds the coordinate stack of the walk. An in-range load returns
// nothing; a read passes through the pixel RAM's registered read port before
// its result is output. In a fill, each popped pixel costs one stack read, one
// coordinate latch and a scan of its four neighbors through the pixel RAM's
// registered read port. Fill and read results, and out-of-range flags, come
// from an output register, so a new transaction is taken while a result waits.
// Write the size registers only while the block is idle. Read only pixels that
// were loaded.
module flood_fill_4way_engine_top #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 64,
   parameter int COLOR_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ffe_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // row[5:0], col[11:6], value[27:12]
   input  logic [1:0]                           req_tuser,  // cmd[1:0]
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ffe_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // pixel_color[15:0]
   output logic [1:0]                           rsp_tuser,  // result_kind[0], out_of_range[1]
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_index,
   input  logic [ffe_pkg::SIZE_BITS-1:0]        csr_data
);

   import ffe_pkg::*;

   logic [SIZE_BITS-1:0]  rows_ff, rows_in, cols_ff, cols_in;
   logic [EXT_BITS-1:0]   rows_eff, cols_eff;
   cmd_in_type            cmd;
   logic                  eng_out_valid, out_free;
   rsp_type               eng_rsp;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   // size registers: always writable, clamp to the built maximum on use
   assign csr_ready = 1'b1;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            CSR_ROWS: rows_in = csr_data;
            CSR_COLS: cols_in = csr_data;
         endcase
      end
   end

   assign rows_eff = (EXT_BITS'(rows_ff) > EXT_BITS'(MAX_ROWS)) ? EXT_BITS'(MAX_ROWS)
                                                                : EXT_BITS'(rows_ff);
   assign cols_eff = (EXT_BITS'(cols_ff) > EXT_BITS'(MAX_COLS)) ? EXT_BITS'(MAX_COLS)
                                                                : EXT_BITS'(cols_ff);

   // unpack the request and flag coordinates outside the size in use
   always_comb begin
      cmd.cmd   = cmd_type'(req_tuser);
      cmd.row   = req_tdata[ROW_BITS-1:0];
      cmd.col   = req_tdata[ROW_BITS +: COL_BITS];
      cmd.value = req_tdata[ROW_BITS + COL_BITS +: VALUE_BITS];
      cmd.bad   = (EXT_BITS'(cmd.row) >= rows_eff) || (EXT_BITS'(cmd.col) >= cols_eff);
   end

   ffe_engine #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .COLOR_BITS (COLOR_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (cmd),
      .rows_eff  (rows_eff),
      .cols_eff  (cols_eff),
      .out_free  (out_free),
      .out_valid (eng_out_valid),
      .out_rsp   (eng_rsp)
   );

   // output register: free when empty or drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (eng_out_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_rsp;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= SIZE_RESET;
         cols_ff      <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.color;
   assign rsp_tuser  = {rsp_ff.oor, rsp_ff.kind};

endmodule

// ===== hdl/ffe_ram.sv =====
`timescale 1ns / 1ps

module ffe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ffe_engine.sv =====
`timescale 1ns / 1ps

module ffe_engine #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 64,
   parameter int COLOR_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  ffe_pkg::cmd_in_type           in_cmd,
   input  logic [ffe_pkg::EXT_BITS-1:0]  rows_eff,
   input  logic [ffe_pkg::EXT_BITS-1:0]  cols_eff,
   input  logic                          out_free,
   output logic                          out_valid,
   output ffe_pkg::rsp_type              out_rsp
);

   import ffe_pkg::*;

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int SW    = RW + CW;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_RESP = 7'b0000010,
      ST_READ = 7'b0000100,
      ST_SEED = 7'b0001000,
      ST_POP  = 7'b0010000,
      ST_LOAD = 7'b0100000,
      ST_SCAN = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [AW:0]             count_ff, count_in, count_dec;
   logic [COLOR_BITS-1:0]   old_ff, old_in, new_ff, new_in;
   logic [RW-1:0]           cur_row_ff, cur_row_in, chk_row_ff, chk_row_in;
   logic [CW-1:0]           cur_col_ff, cur_col_in, chk_col_ff, chk_col_in;
   logic                    chk_valid_ff, chk_valid_in;
   logic [2:0]              k_ff, k_in;
   kind_type                resp_kind_ff, resp_kind_in;
   logic                    resp_oor_ff, resp_oor_in;

   logic                    px_we, px_re;
   logic [AW-1:0]           px_waddr, px_raddr;
   logic [COLOR_BITS-1:0]   px_wdata, px_rdata;
   logic                    st_we, st_re;
   logic [AW-1:0]           st_waddr, st_raddr;
   logic [SW-1:0]           st_wdata, st_rdata;

   logic [RW-1:0]           in_row, nb_row;
   logic [CW-1:0]           in_col, nb_col;
   logic                    nb_ok;
   dir_type                 dir;

   function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
      addr_of = AW'(AW'(r) * AW'(MAX_COLS) + AW'(c));
   endfunction

   ffe_ram #(.WIDTH(COLOR_BITS), .DEPTH(CELLS)) u_pixel_ram (
      .clock   (clock),
      .wr_en   (px_we),
      .wr_addr (px_waddr),
      .wr_data (px_wdata),
      .rd_en   (px_re),
      .rd_addr (px_raddr),
      .rd_data (px_rdata)
   );

   ffe_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   assign in_row    = RW'(in_cmd.row);
   assign in_col    = CW'(in_cmd.col);
   assign count_dec = count_ff - 1'b1;
   assign dir       = dir_type'(k_ff[1:0]);

   // neighbor of the popped pixel selected by the scan step
   always_comb begin
      nb_row = cur_row_ff;
      nb_col = cur_col_ff;
      nb_ok  = 1'b0;
      unique case (dir)
         DIR_UP: begin
            nb_ok  = cur_row_ff != '0;
            nb_row = cur_row_ff - 1'b1;
         end
         DIR_DOWN: begin
            nb_ok  = (EXT_BITS'(cur_row_ff) + 1'b1) < rows_eff;
            nb_row = cur_row_ff + 1'b1;
         end
         DIR_RIGHT: begin
            nb_ok  = (EXT_BITS'(cur_col_ff) + 1'b1) < cols_eff;
            nb_col = cur_col_ff + 1'b1;
         end
         DIR_LEFT: begin
            nb_ok  = cur_col_ff != '0;
            nb_col = cur_col_ff - 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      old_in       = old_ff;
      new_in       = new_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      chk_row_in   = chk_row_ff;
      chk_col_in   = chk_col_ff;
      chk_valid_in = chk_valid_ff;
      k_in         = k_ff;
      resp_kind_in = resp_kind_ff;
      resp_oor_in  = resp_oor_ff;
      px_we        = 1'b0;
      px_waddr     = addr_of(cur_row_ff, cur_col_ff);
      px_wdata     = new_ff;
      px_re        = 1'b0;
      px_raddr     = addr_of(in_row, in_col);
      st_we        = 1'b0;
      st_waddr     = count_ff[AW-1:0];
      st_wdata     = {cur_row_ff, cur_col_ff};
      st_re        = 1'b0;
      st_raddr     = count_dec[AW-1:0];
      in_ready     = state_ff == ST_IDLE;
      out_valid    = 1'b0;
      out_rsp      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               if (in_cmd.cmd != CMD_NONE && in_cmd.bad) begin
                  resp_kind_in = (in_cmd.cmd == CMD_FILL) ? KIND_FILL : KIND_READ;
                  resp_oor_in  = 1'b1;
                  state_in     = ST_RESP;
               end else begin
                  unique case (in_cmd.cmd)
                     CMD_LOAD: begin
                        px_we    = 1'b1;
                        px_waddr = addr_of(in_row, in_col);
                        px_wdata = COLOR_BITS'(in_cmd.value);
                     end
                     CMD_READ: begin
                        px_re    = 1'b1;
                        state_in = ST_READ;
                     end
                     CMD_FILL: begin
                        px_re      = 1'b1;
                        cur_row_in = in_row;
                        cur_col_in = in_col;
                        new_in     = COLOR_BITS'(in_cmd.value);
                        state_in   = ST_SEED;
                     end
                     CMD_NONE: begin
                     end
                  endcase
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               out_valid    = 1'b1;
               out_rsp.kind = resp_kind_ff;
               out_rsp.oor  = resp_oor_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            if (out_free) begin
               out_valid     = 1'b1;
               out_rsp.kind  = KIND_READ;
               out_rsp.color = VALUE_BITS'(px_rdata);
               state_in      = ST_IDLE;
            end
         end
         ST_SEED: begin
            old_in = px_rdata;
            if (px_rdata == new_ff) begin
               resp_kind_in = KIND_FILL;
               resp_oor_in  = 1'b0;
               state_in     = ST_RESP;
            end else begin
               px_we    = 1'b1;
               st_we    = 1'b1;
               st_waddr = '0;
               count_in = (AW + 1)'(1);
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (count_ff == '0) begin
               resp_kind_in = KIND_FILL;
               resp_oor_in  = 1'b0;
               state_in     = ST_RESP;
            end else begin
               st_re    = 1'b1;
               count_in = count_dec;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            {cur_row_in, cur_col_in} = st_rdata;
            k_in         = '0;
            chk_valid_in = 1'b0;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            // compare the neighbor read last cycle; recolor and push on a match
            if (chk_valid_ff && px_rdata == old_ff) begin
               px_we    = 1'b1;
               px_waddr = addr_of(chk_row_ff, chk_col_ff);
               st_we    = 1'b1;
               st_wdata = {chk_row_ff, chk_col_ff};
               count_in = count_ff + 1'b1;
            end
            // issue the next neighbor read; all four are distinct from the write
            if (!k_ff[2]) begin
               chk_valid_in = nb_ok;
               chk_row_in   = nb_row;
               chk_col_in   = nb_col;
               px_re        = nb_ok;
               px_raddr     = addr_of(nb_row, nb_col);
               k_in         = k_ff + 1'b1;
            end else begin
               chk_valid_in = 1'b0;
               state_in     = ST_POP;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         old_ff       <= '0;
         new_ff       <= '0;
         chk_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         old_ff       <= old_in;
         new_ff       <= new_in;
         chk_valid_ff <= chk_valid_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_row_ff   <= cur_row_in;
      cur_col_ff   <= cur_col_in;
      chk_row_ff   <= chk_row_in;
      chk_col_ff   <= chk_col_in;
      resp_kind_ff <= resp_kind_in;
      resp_oor_ff  <= resp_oor_in;
   end

endmodule

// ===== hdl/ffe_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffe_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [ffe_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input logic [1:0]                         req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [ffe_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic [1:0]                         rsp_tuser,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic                               csr_index,
   input logic [ffe_pkg::SIZE_BITS-1:0]      csr_data
);

   import ffe_pkg::*;

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // fill results carry no color
   `ASSERT_IMPL(a_fill_no_color, clock, reset, rsp_tvalid && rsp_tuser[TUSER_KIND], rsp_tdata == '0)
   // rejected coordinates carry no color
   `ASSERT_IMPL(a_oor_no_color, clock, reset, rsp_tvalid && rsp_tuser[TUSER_OOR], rsp_tdata == '0)
   // size writes never stall
   `ASSERT_IMPL(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind flood_fill_4way_engine_top ffe_checker u_checker (.*);

// ===== tb/tb_flood_fill_4way_engine_top.sv =====
`timescale 1ns / 1ps

module tb_flood_fill_4way_engine_top;
   import ffe_pkg::*;

   localparam int GRID_ROWS     = 64;
   localparam int GRID_COLS     = 64;
   localparam int GRID_CELLS    = GRID_ROWS * GRID_COLS;
   localparam int ITEM_TARGET   = 1800;
   localparam int QUIET_TAIL    = 200;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 5000000;
   localparam int PRELOAD_MAX   = 256;

   // One line of the directed plan: either a size register write or a request
   // transaction, optionally with its response spelled out by hand.
   typedef struct {
      bit                    is_csr;
      csr_reg_type           csr_reg;
      logic [SIZE_BITS-1:0]  csr_val;
      cmd_type               cmd;
      int                    row;
      int                    col;
      logic [VALUE_BITS-1:0] value;
      bit                    typed;
      rsp_type               want;
   } plan_step_type;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [1:0]               req_tuser  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [1:0]               rsp_tuser;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic                     csr_index  = 1'b0;
   logic [SIZE_BITS-1:0]     csr_data   = '0;

   // Shadow image, its load map and the shadow size registers.
   logic [VALUE_BITS-1:0]    shadow_pix [GRID_CELLS];
   bit                       pix_loaded [GRID_CELLS];
   logic [SIZE_BITS-1:0]     rows_reg = SIZE_RESET;
   logic [SIZE_BITS-1:0]     cols_reg = SIZE_RESET;

   rsp_type                  pending_rsp [$];
   logic [VALUE_BITS-1:0]    palette [3];
   int                       mismatch_count = 0;
   int                       cycle_count    = 0;
   int                       stall_left     = 0;
   bit                       bursts_on      = 1'b1;

   flood_fill_4way_engine_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Size registers above the grid clamp to the grid.
   function automatic int rows_live();
      return (rows_reg > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
   endfunction

   function automatic int cols_live();
      return (cols_reg > GRID_COLS) ? GRID_COLS : int'(cols_reg);
   endfunction

   // Advance the shadow image by one accepted request and return 1 when the
   // request produces a response, which is then left in rsp.
   function automatic bit predict_pixel_op(input cmd_type cmd, input int row, input int col,
                                           input logic [VALUE_BITS-1:0] value,
                                           output rsp_type rsp);
      bit                    off_grid;
      int                    addr;
      int                    here;
      int                    nr;
      int                    nc;
      int                    walk [$];
      logic [VALUE_BITS-1:0] old_color;

      off_grid  = (row >= rows_live()) || (col >= cols_live());
      addr      = row * GRID_COLS + col;
      rsp.kind  = (cmd == CMD_FILL) ? KIND_FILL : KIND_READ;
      rsp.color = '0;
      rsp.oor   = off_grid;
      if (cmd == CMD_NONE)
         return 1'b0;
      if (off_grid)
         return 1'b1;
      case (cmd)
         CMD_LOAD: begin
            shadow_pix[addr] = value;
            pix_loaded[addr] = 1'b1;
            return 1'b0;
         end
         CMD_FILL: begin
            // Recolor on push so that no pixel enters the walk twice.
            old_color = shadow_pix[addr];
            if (old_color != value) begin
               shadow_pix[addr] = value;
               walk.push_back(addr);
               while (walk.size() > 0) begin
                  here = walk.pop_back();
                  for (int k = 0; k < 4; k++) begin
                     nr = here / GRID_COLS;
                     nc = here % GRID_COLS;
                     case (dir_type'(k))
                        DIR_UP:    nr = nr - 1;
                        DIR_DOWN:  nr = nr + 1;
                        DIR_RIGHT: nc = nc + 1;
                        default:   nc = nc - 1;
                     endcase
                     if (nr >= 0 && nc >= 0 && nr < rows_live() && nc < cols_live()
                         && shadow_pix[nr * GRID_COLS + nc] == old_color) begin
                        shadow_pix[nr * GRID_COLS + nc] = value;
                        walk.push_back(nr * GRID_COLS + nc);
                     end
                  end
               end
            end
         end
         default: rsp.color = shadow_pix[addr];
      endcase
      return 1'b1;
   endfunction

   function automatic plan_step_type item_step(input cmd_type cmd, input int row, input int col,
                                               input logic [VALUE_BITS-1:0] value,
                                               input bit typed = 1'b0,
                                               input kind_type kind = KIND_READ,
                                               input logic [VALUE_BITS-1:0] color = '0,
                                               input logic oor = 1'b0);
      plan_step_type s;
      s.is_csr     = 1'b0;
      s.csr_reg    = CSR_ROWS;
      s.csr_val    = '0;
      s.cmd        = cmd;
      s.row        = row;
      s.col        = col;
      s.value      = value;
      s.typed      = typed;
      s.want.kind  = kind;
      s.want.color = color;
      s.want.oor   = oor;
      return s;
   endfunction

   function automatic plan_step_type csr_step(input csr_reg_type which,
                                              input logic [SIZE_BITS-1:0] val);
      plan_step_type s;
      s         = item_step(CMD_NONE, 0, 0, '0);
      s.is_csr  = 1'b1;
      s.csr_reg = which;
      s.csr_val = val;
      return s;
   endfunction

   // Mostly colors from the phase palette, so regions connect; sometimes any color.
   function automatic logic [VALUE_BITS-1:0] pick_shade();
      if ($urandom_range(0, 9) < 8)
         return palette[$urandom_range(0, 2)];
      return VALUE_BITS'($urandom);
   endfunction

   // Drive one request transaction; hold it until accepted, then log its
   // response. Valid stays high into the next call unless a gap is inserted.
   task automatic send_pixel_op(input cmd_type cmd, input int row, input int col,
                                input logic [VALUE_BITS-1:0] value,
                                input bit typed, input rsp_type want);
      rsp_type guess;
      @(negedge clock);
      if (bursts_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, value, COL_BITS'(col), ROW_BITS'(row)};
      do @(posedge clock); while (!req_tready);
      if (predict_pixel_op(cmd, row, col, value, guess))
         pending_rsp.push_back(typed ? want : guess);
   endtask

   // Drop valid, wait for every outstanding response, then let trailing loads land.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_reg_type which, input logic [SIZE_BITS-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (which == CSR_ROWS)
         rows_reg = val;
      else
         cols_reg = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Response side back-pressure: random stalls while bursts are on.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare every accepted response against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: kind %0d color %h oor %0d",
                        rsp_tuser[TUSER_KIND], rsp_tdata, rsp_tuser[TUSER_OOR]);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tuser[TUSER_KIND] !== want.kind || rsp_tdata !== want.color
                || rsp_tuser[TUSER_OOR] !== want.oor) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response mismatch: expected kind %0d color %h oor %0d, got kind %0d color %h oor %0d",
                           want.kind, want.color, want.oor,
                           rsp_tuser[TUSER_KIND], rsp_tdata, rsp_tuser[TUSER_OOR]);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      plan_step_type plan [$];
      rsp_type    blank;
      cmd_type    cmd;
      int         row;
      int         col;
      int         pick;
      int         area;
      int         ops;
      int         phase;
      int         fresh_items;
      int         rows_set;
      int         cols_set;
      bit         whole;

      blank = '0;

      // Directed plan, starting from the reset size of 64 x 64.
      plan.push_back(item_step(CMD_LOAD, 0, 0, 16'h0000));
      plan.push_back(item_step(CMD_LOAD, 63, 63, 16'hFFFF));
      plan.push_back(item_step(CMD_LOAD, 0, 63, 16'hA5A5));
      plan.push_back(item_step(CMD_LOAD, 63, 0, 16'h5A5A));
      plan.push_back(item_step(CMD_READ, 0, 0, 16'h1111, 1'b1, KIND_READ, 16'h0000, 1'b0));
      plan.push_back(item_step(CMD_READ, 63, 63, 16'h0, 1'b1, KIND_READ, 16'hFFFF, 1'b0));
      plan.push_back(item_step(CMD_READ, 0, 63, 16'h0, 1'b1, KIND_READ, 16'hA5A5, 1'b0));
      // Unused command: no response at all.
      plan.push_back(item_step(CMD_NONE, 12, 34, 16'h1234));
      // Shrink to 2 x 2, load every pixel of it, then fill from the seed.
      plan.push_back(csr_step(CSR_ROWS, 7'd2));
      plan.push_back(csr_step(CSR_COLS, 7'd2));
      plan.push_back(item_step(CMD_LOAD, 0, 1, 16'h0000));
      plan.push_back(item_step(CMD_LOAD, 1, 0, 16'h1234));
      plan.push_back(item_step(CMD_LOAD, 1, 1, 16'h0000));
      plan.push_back(item_step(CMD_FILL, 0, 0, 16'h0007, 1'b1, KIND_FILL, 16'h0, 1'b0));
      plan.push_back(item_step(CMD_READ, 1, 1, 16'h0));
      plan.push_back(item_step(CMD_READ, 1, 0, 16'h0));
      // Fill with the color already there changes nothing; a fill of a lone pixel follows.
      plan.push_back(item_step(CMD_FILL, 0, 0, 16'h0007, 1'b1, KIND_FILL, 16'h0, 1'b0));
      plan.push_back(item_step(CMD_FILL, 1, 0, 16'hFFFF, 1'b1, KIND_FILL, 16'h0, 1'b0));
      plan.push_back(item_step(CMD_READ, 0, 1, 16'h0));
      // Off-grid load, fill and read: flagged, nothing changes.
      plan.push_back(item_step(CMD_LOAD, 2, 0, 16'h9999, 1'b1, KIND_READ, 16'h0, 1'b1));
      plan.push_back(item_step(CMD_FILL, 0, 2, 16'h0001, 1'b1, KIND_FILL, 16'h0, 1'b1));
      plan.push_back(item_step(CMD_READ, 63, 63, 16'h0, 1'b1, KIND_READ, 16'h0, 1'b1));
      // Zero rows: every coordinate is off the grid.
      plan.push_back(csr_step(CSR_ROWS, 7'd0));
      plan.push_back(item_step(CMD_READ, 0, 0, 16'h0, 1'b1, KIND_READ, 16'h0, 1'b1));
      // Sizes above the grid clamp to it; far corners are back in range.
      plan.push_back(csr_step(CSR_ROWS, 7'd127));
      plan.push_back(csr_step(CSR_COLS, 7'd127));
      plan.push_back(item_step(CMD_READ, 63, 63, 16'h0, 1'b1, KIND_READ, 16'hFFFF, 1'b0));
      plan.push_back(item_step(CMD_READ, 63, 0, 16'h0, 1'b1, KIND_READ, 16'h5A5A, 1'b0));
      plan.push_back(item_step(CMD_READ, 1, 0, 16'h0));

      // Hold reset, then release it on a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle();
            write_csr(plan[i].csr_reg, plan[i].csr_val);
         end else begin
            send_pixel_op(plan[i].cmd, plan[i].row, plan[i].col, plan[i].value,
                          plan[i].typed, plan[i].want);
         end
      end

      // Random phases. Each phase picks a size, paints the whole region when it
      // is small, then mixes loads, reads of loaded pixels, fills, unused commands
      // and off-grid requests. Fills run only if all pixels they may touch are loaded.
      phase       = 0;
      fresh_items = 0;
      while (fresh_items < ITEM_TARGET) begin
         case (phase)
            0: begin rows_set = 1;   cols_set = 1;   end
            1: begin rows_set = 64;  cols_set = 1;   end
            2: begin rows_set = 1;   cols_set = 64;  end
            3: begin rows_set = 0;   cols_set = 5;   end
            4: begin rows_set = 6;   cols_set = 0;   end
            5: begin rows_set = 127; cols_set = 3;   end
            6: begin rows_set = 64;  cols_set = 64;  end
            7: begin rows_set = 3;   cols_set = 100; end
            default: begin
               rows_set = $urandom_range(1, 8);
               cols_set = $urandom_range(1, 8);
            end
         endcase
         settle();
         write_csr(CSR_ROWS, SIZE_BITS'(rows_set));
         write_csr(CSR_COLS, SIZE_BITS'(cols_set));
         // No gaps or stalls in the final stretch; some phases run gap-free too.
         bursts_on = (fresh_items < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         for (int k = 0; k < 3; k++)
            palette[k] = VALUE_BITS'($urandom);

         area = rows_live() * cols_live();
         if (area > 0 && area <= PRELOAD_MAX) begin
            for (int r = 0; r < rows_live(); r++)
               for (int c = 0; c < cols_live(); c++) begin
                  send_pixel_op(CMD_LOAD, r, c, pick_shade(), 1'b0, blank);
                  fresh_items++;
               end
         end

         ops = (area > PRELOAD_MAX) ? 250 : 60;
         for (int n = 0; n < ops; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               send_pixel_op(CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                             VALUE_BITS'($urandom), 1'b0, blank);
               continue;
            end
            cmd = (pick < 40) ? CMD_LOAD : ((pick < 70) ? CMD_READ : CMD_FILL);
            if (area == 0 || (area < GRID_CELLS && $urandom_range(0, 9) == 0)) begin
               // Off-grid coordinates on whichever axis leaves room for them.
               if (rows_live() < GRID_ROWS
                   && (cols_live() == GRID_COLS || $urandom_range(0, 1) == 0)) begin
                  row = $urandom_range(rows_live(), GRID_ROWS - 1);
                  col = $urandom_range(0, GRID_COLS - 1);
               end else begin
                  row = $urandom_range(0, GRID_ROWS - 1);
                  col = $urandom_range(cols_live(), GRID_COLS - 1);
               end
            end else begin
               row = $urandom_range(0, rows_live() - 1);
               col = $urandom_range(0, cols_live() - 1);
               if (cmd == CMD_FILL) begin
                  whole = 1'b1;
                  for (int r = 0; r < rows_live(); r++)
                     for (int c = 0; c < cols_live(); c++)
                        if (!pix_loaded[r * GRID_COLS + c])
                           whole = 1'b0;
                  if (!whole)
                     cmd = CMD_READ;
               end
               // Never read a pixel that was not written; write it instead.
               if (cmd == CMD_READ && !pix_loaded[row * GRID_COLS + col])
                  cmd = CMD_LOAD;
            end
            send_pixel_op(cmd, row, col, pick_shade(), 1'b0, blank);
            fresh_items++;
         end
         phase++;
      end

      settle();
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ffe_pkg.sv
hdl/ffe_ram.sv
hdl/ffe_engine.sv
hdl/flood_fill_4way_engine_top.sv
hdl/ffe_checker.sv
tb/tb_flood_fill_4way_engine_top.sv
